>>> src/pwdv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwdv_pkg
// Shared types and constants for the page word decrypt and verify block.
// ----------------------------------------------------------------------------
package pwdv_pkg;

  // Page geometry
  localparam int unsigned WORDS_PER_PAGE = 1024;
  localparam int unsigned POS_W          = (WORDS_PER_PAGE > 1) ? $clog2(WORDS_PER_PAGE) : 1;
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(WORDS_PER_PAGE - 1);

  // Data path widths
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned HALF_W    = 16;
  localparam int unsigned KEY_IDX_W = 8;
  localparam int unsigned KEY_DEPTH = 256;
  localparam int unsigned KEY_LANES = 4;

  // Table pages start from the page index with its low nine bits cleared
  localparam logic [WORD_W-1:0] SEED_CLR_MASK = 32'h0000_01FF;

  // Item kinds; the fourth code is unused and dropped
  typedef enum logic [1:0] {
    MODE_KEY   = 2'd0,
    MODE_TABLE = 2'd1,
    MODE_DATA  = 2'd2
  } mode_e;

  // Key table write request
  typedef struct packed {
    logic                 en;
    logic [KEY_IDX_W-1:0] idx;
    logic [WORD_W-1:0]    data;
  } key_wr_t;

  // One key word per byte lane of the previous cipher word
  typedef logic [KEY_LANES-1:0][WORD_W-1:0] key_quad_t;

endpackage

>>> src/pwdv_key_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwdv_key_lookup
// Key table held in four identical banks, one per byte lane, so the four
// lookups of a word happen in the same cycle with registered read data.
// ----------------------------------------------------------------------------
module pwdv_key_lookup
  import pwdv_pkg::*;
(
  input  logic              clk_i,
  input  key_wr_t           wr_i,
  input  logic              rd_en_i,
  input  logic [WORD_W-1:0] rd_word_i,
  output key_quad_t         keys_o
);

  for (genvar g = 0; g < KEY_LANES; g++) begin : g_bank
    logic [WORD_W-1:0] mem [KEY_DEPTH];
    logic [WORD_W-1:0] rd_q;

    // Write every bank alike; read the entry picked by this byte lane
    always_ff @(posedge clk_i) begin
      if (wr_i.en) begin
        mem[wr_i.idx] <= wr_i.data;
      end
      if (rd_en_i) begin
        rd_q <= mem[rd_word_i[KEY_IDX_W*g +: KEY_IDX_W]];
      end
    end

    assign keys_o[g] = rd_q;
  end

endmodule

>>> src/page_word_decrypt_verify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_word_decrypt_verify
// Chained page word decryption with a rotate-xor checksum on data pages.
//
//   channel  dir  handshake              beat
//   in       in   in_valid_i/in_stall_o  mode, key_index, data_word, seed
//   out      out  out_valid_o/out_stall_i plain_word, page_end, checksum_ok
//
// One beat per cycle sustained while the output is not stalled. At the
// accepting edge the page word enters the first stage and the key banks
// are read; the mask, plaintext and checksum are formed from these
// registers and loaded into the output register once it can take them.
// Key loads and unused codes give no output beat.
// Reset clears the page position, chain state and both pipeline valids;
// the key table is not cleared. A stalled output holds its beat while one
// more word waits in the first stage, then the input stalls.
// ----------------------------------------------------------------------------
module page_word_decrypt_verify
  import pwdv_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           mode_i,
  input  logic [KEY_IDX_W-1:0] key_index_i,
  input  logic [WORD_W-1:0]    data_word_i,
  input  logic [WORD_W-1:0]    seed_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [WORD_W-1:0]    plain_word_o,
  output logic                 page_end_o,
  output logic                 checksum_ok_o
);

  mode_e             mode;
  logic              accept, is_word, word_acc;
  logic              first, last, page_data_cur;
  logic [WORD_W-1:0] seed_cur, prev_cur;
  key_wr_t           key_wr;
  key_quad_t         keys;

  // Page state
  logic [POS_W-1:0]  pos_q;
  logic [WORD_W-1:0] prev_q, page_seed_q;
  logic              page_is_data_q;

  // First stage
  logic              s1_valid_q;
  logic [WORD_W-1:0] s1_cipher_q, s1_prev_q, s1_seed_q;
  logic              s1_data_q, s1_first_q, s1_last_q;

  // Second stage and checksum
  logic              out_ready, s1_ready, s1_adv;
  logic [WORD_W-1:0] mask, plain, x_word, cs_base, cs_d, cs_q;
  logic              ok;
  logic              out_valid_q, page_end_q, checksum_ok_q;
  logic [WORD_W-1:0] plain_q;

  // Decode the incoming beat
  always_comb begin
    mode    = mode_e'(mode_i);
    is_word = 1'b0;
    case (mode)
      MODE_TABLE: is_word = 1'b1;
      MODE_DATA:  is_word = 1'b1;
      default:    is_word = 1'b0;
    endcase
  end

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign s1_adv     = s1_valid_q && out_ready;
  assign in_stall_o = !s1_ready;
  assign accept     = in_valid_i && !in_stall_o;
  assign word_acc   = accept && is_word;

  // Latch page kind and seed at the first word of a page
  assign first         = (pos_q == '0);
  assign last          = (pos_q == LAST_POS);
  assign page_data_cur = first ? (mode == MODE_DATA) : page_is_data_q;
  assign seed_cur      = first ? seed_i : page_seed_q;
  assign prev_cur      = !first ? prev_q :
                         ((mode == MODE_DATA) ? seed_i : (seed_i & ~SEED_CLR_MASK));

  assign key_wr.en   = accept && (mode == MODE_KEY);
  assign key_wr.idx  = key_index_i;
  assign key_wr.data = data_word_i;

  pwdv_key_lookup u_keys (
    .clk_i     (clk_i),
    .wr_i      (key_wr),
    .rd_en_i   (word_acc),
    .rd_word_i (prev_cur),
    .keys_o    (keys)
  );

  // Advance page position and chain on each page word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q          <= '0;
      prev_q         <= '0;
      page_seed_q    <= '0;
      page_is_data_q <= 1'b0;
    end else if (word_acc) begin
      pos_q          <= last ? '0 : pos_q + POS_W'(1);
      prev_q         <= data_word_i;
      page_seed_q    <= seed_cur;
      page_is_data_q <= page_data_cur;
    end
  end

  // First stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= word_acc;
    end
  end

  // First stage payload
  always_ff @(posedge clk_i) begin
    if (word_acc) begin
      s1_cipher_q <= data_word_i;
      s1_prev_q   <= prev_cur;
      s1_seed_q   <= seed_cur;
      s1_data_q   <= page_data_cur;
      s1_first_q  <= first;
      s1_last_q   <= last;
    end
  end

  // Form mask, plaintext and checksum
  always_comb begin
    mask    = keys[0] + keys[1] + keys[2] + keys[3];
    x_word  = s1_prev_q ^ s1_cipher_q ^ mask;
    plain   = s1_data_q ? (s1_cipher_q - (s1_prev_q ^ mask))
                        : {x_word[HALF_W-1:0], x_word[WORD_W-1:HALF_W]};
    cs_base = s1_first_q ? '0 : cs_q;
    cs_d    = {cs_base[WORD_W-2:0], cs_base[WORD_W-1]} ^ plain;
    ok      = s1_data_q && s1_last_q &&
              ((cs_d | WORD_W'(1)) == s1_seed_q);
  end

  // Hold the running checksum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q <= '0;
    end else if (s1_adv && s1_data_q) begin
      cs_q <= cs_d;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      plain_q       <= plain;
      page_end_q    <= s1_last_q;
      checksum_ok_q <= ok;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign plain_word_o  = plain_q;
  assign page_end_o    = page_end_q;
  assign checksum_ok_o = checksum_ok_q;

endmodule

>>> src/pwdv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwdv_checker
// Port level checks for the page word decrypt and verify block.
// ----------------------------------------------------------------------------
module pwdv_checker
  import pwdv_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic [1:0]           mode_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [WORD_W-1:0]    plain_word_o,
  input logic                 page_end_o,
  input logic                 checksum_ok_o
);

  // Stalled output beat stays valid
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // Stalled output beat keeps its payload
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(plain_word_o) && $stable(page_end_o) && $stable(checksum_ok_o))
    else $error("output payload changed while stalled");

  // A checksum match is only flagged on the last word of a page
  a_ok_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && checksum_ok_o |-> page_end_o)
    else $error("checksum flag away from page end");

  // A fresh output beat must come from an accepted page word
  a_out_from_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && !in_stall_o &&
            (mode_i == MODE_TABLE || mode_i == MODE_DATA), 2))
    else $error("output beat without a page word");

endmodule

bind page_word_decrypt_verify pwdv_checker u_pwdv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .mode_i        (mode_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .plain_word_o  (plain_word_o),
  .page_end_o    (page_end_o),
  .checksum_ok_o (checksum_ok_o)
);

>>> dv/page_word_decrypt_verify_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_word_decrypt_verify_test
// Self-checking bench for the chained page word decryptor. It fills the key
// table, runs a whole data page built to pass the checksum against an
// all-ones seed, then part of a table page, and mixes in key loads, unused
// codes and kind swaps inside pages. A scoreboard predicts every output beat
// and checks the outputs in order while both sides mostly idle and stall at random.
// ----------------------------------------------------------------------------

class decrypt_scoreboard;

  typedef struct packed {
    logic [31:0] plain;
    logic        last;
    logic        ok;
  } beat_t;

  // Predictor state
  logic [31:0] keys [256];
  logic [31:0] chain;
  logic [31:0] csum;
  logic [31:0] page_seed;
  logic        is_data;
  int unsigned pos;

  beat_t       expected [$];

  // Run statistics
  int unsigned errors;
  int unsigned key_writes;
  int unsigned dropped;
  int unsigned words;
  int unsigned swaps;
  int unsigned page_ends;
  int unsigned ok_hits;

  function new();
    chain = '0;
    csum = '0;
    page_seed = '0;
    is_data = 1'b0;
    pos = 0;
    errors = 0;
    key_writes = 0;
    dropped = 0;
    words = 0;
    swaps = 0;
    page_ends = 0;
    ok_hits = 0;
  endfunction

  function int unsigned pending();
    return expected.size();
  endfunction

  // Sum of the four key words picked by the bytes of the previous cipher word
  function logic [31:0] key_sum(logic [31:0] w);
    return keys[w[7:0]] + keys[w[15:8]] + keys[w[23:16]] + keys[w[31:24]];
  endfunction

  // Cipher for the last word of a data page that steers the checksum to goal
  function logic [31:0] cipher_for_goal(logic [31:0] goal);
    logic [31:0] plain;
    plain = {csum[30:0], csum[31]} ^ goal;
    return plain + (chain ^ key_sum(chain));
  endfunction

  // Note an accepted input beat and queue the result it causes
  function void note_beat(logic [1:0] mode, logic [7:0] idx, logic [31:0] word,
                          logic [31:0] seed);
    beat_t       r;
    logic [31:0] m;
    logic [31:0] x;
    if (mode == pwdv_pkg::MODE_KEY) begin
      keys[idx] = word;
      key_writes++;
      return;
    end
    if (mode != pwdv_pkg::MODE_TABLE && mode != pwdv_pkg::MODE_DATA) begin
      dropped++;
      return;
    end
    // Latch page kind and seed on the first word
    if (pos == 0) begin
      is_data = (mode == pwdv_pkg::MODE_DATA);
      page_seed = seed;
      csum = '0;
      chain = is_data ? seed : (seed & ~pwdv_pkg::SEED_CLR_MASK);
    end else if ((mode == pwdv_pkg::MODE_DATA) != is_data) begin
      swaps++;
    end
    m = key_sum(chain);
    if (is_data) begin
      r.plain = word - (chain ^ m);
      csum = {csum[30:0], csum[31]} ^ r.plain;
    end else begin
      x = chain ^ word ^ m;
      r.plain = {x[15:0], x[31:16]};
    end
    chain = word;
    r.last = (pos == pwdv_pkg::WORDS_PER_PAGE - 1);
    r.ok = r.last && is_data && ((csum | 32'd1) == page_seed);
    pos = r.last ? 0 : pos + 1;
    words++;
    expected.push_back(r);
  endfunction

  // Compare an accepted output beat with the oldest prediction
  function void check_beat(logic [31:0] plain, logic last, logic ok);
    beat_t e;
    if (expected.size() == 0) begin
      errors++;
      if (errors <= 200)
        $display("%0t: output beat with nothing expected: plain %h end %b ok %b",
                 $time, plain, last, ok);
      return;
    end
    e = expected.pop_front();
    if (plain !== e.plain || last !== e.last || ok !== e.ok) begin
      errors++;
      if (errors <= 200)
        $display("%0t: mismatch: expected plain %h end %b ok %b, got plain %h end %b ok %b",
                 $time, e.plain, e.last, e.ok, plain, last, ok);
    end
    if (last === 1'b1) page_ends++;
    if (ok === 1'b1) ok_hits++;
  endfunction

endclass

module page_word_decrypt_verify_test;
  import pwdv_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i      = '0;
  logic [7:0]  key_index_i = '0;
  logic [31:0] data_word_i = '0;
  logic [31:0] seed_i      = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] plain_word_o;
  logic        page_end_o;
  logic        checksum_ok_o;

  bit calm = 1'b0;

  decrypt_scoreboard sb = new();

  page_word_decrypt_verify dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .key_index_i  (key_index_i),
    .data_word_i  (data_word_i),
    .seed_i       (seed_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .plain_word_o (plain_word_o),
    .page_end_o   (page_end_o),
    .checksum_ok_o(checksum_ok_o)
  );

  always #5 clk_i = ~clk_i;

  // Check each output beat, then pick the stall for the next cycle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i)
        sb.check_beat(plain_word_o, page_end_o, checksum_ok_o);
      out_stall_i <= !calm && ($urandom_range(99) < 16);
    end
  end

  // Offer one input beat after a random gap and hold it until accepted
  task automatic send_beat(input logic [1:0] mode, input logic [7:0] idx,
                           input logic [31:0] word, input logic [31:0] seed);
    while (!calm && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    key_index_i <= idx;
    data_word_i <= word;
    seed_i      <= seed;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_beat(mode, idx, word, seed);
  endtask

  // Hold the input idle until every predicted beat has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Finish the current page (or run a whole one) with random content,
  // stopping early once limit beats have gone out
  task automatic run_page(input logic [1:0] kind, input logic [31:0] seed,
                          input bit aim, input logic [31:0] goal, input bit quiet,
                          input int unsigned limit);
    int unsigned pick;
    int unsigned sent;
    logic [1:0]  mode;
    logic [31:0] word;
    bit          started;
    started = (sb.pos != 0);
    sent = 0;
    calm = quiet;
    while ((!started || sb.pos != 0) && sent < limit) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_beat(MODE_KEY, 8'($urandom), $urandom, $urandom);
      end else if (pick < 7) begin
        send_beat(MODE_NONE, 8'($urandom), $urandom, $urandom);
      end else begin
        mode = kind;
        if (sb.pos != 0 && pick < 12)
          mode = (kind == MODE_DATA) ? MODE_TABLE : MODE_DATA;
        word = (aim && sb.pos == WORDS_PER_PAGE - 1) ? sb.cipher_for_goal(goal)
                                                     : $urandom;
        send_beat(mode, 8'($urandom), word, (sb.pos == 0) ? seed : $urandom);
        started = 1'b1;
      end
      sent++;
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every key entry before any page word reads the table
    for (int i = 0; i < 256; i++)
      send_beat(MODE_KEY, 8'(i), (i == 0) ? 32'hFFFF_FFFF : $urandom, $urandom);

    // Directed start of a data page: extremes, unused code, kind swap,
    // key reloads in mid-page
    send_beat(MODE_DATA,  8'h00, 32'h0000_0000, 32'hFFFF_FFFF);
    send_beat(MODE_NONE,  8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(MODE_TABLE, 8'h00, 32'hFFFF_FFFF, 32'h0000_0000);
    send_beat(MODE_KEY,   8'hFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_beat(MODE_KEY,   8'h00, 32'hFFFF_FFFF, 32'h0000_0000);
    send_beat(MODE_DATA,  8'hFF, 32'hFF00_00FF, 32'h0000_0000);
    send_beat(MODE_DATA,  8'h00, 32'h8000_0001, 32'h5555_5555);
    send_beat(MODE_TABLE, 8'h5A, 32'h7FFF_FFFE, 32'hAAAA_AAAA);
    send_beat(MODE_NONE,  8'h00, 32'h0000_0000, 32'h0000_0000);
    send_beat(MODE_DATA,  8'hA5, 32'h0001_0000, 32'hFFFF_FFFF);

    // Finish it so the checksum equals the all-ones seed
    run_page(MODE_DATA, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0, 4096);

    // Let the pipe run dry
    drain();

    // Part of a table page from an all-ones index, with no idling once the random part starts
    send_beat(MODE_TABLE, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF);
    send_beat(MODE_DATA,  8'h00, 32'hFFFF_FFFF, 32'h0000_0000);
    run_page(MODE_TABLE, 32'hFFFF_FFFF, 1'b0, '0, 1'b1, 240);

    drain();
    repeat (8) @(posedge clk_i);

    $display("covered %0d key writes, %0d ignored beats, %0d page words, %0d kind swaps",
             sb.key_writes, sb.dropped, sb.words, sb.swaps);
    $display("saw %0d page ends and %0d checksum matches, %0d errors",
             sb.page_ends, sb.ok_hits, sb.errors);
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
